### hdl/lptc_pkg.sv
// ----------------------------------------------------------------------------
// lptc_pkg
// Shared types and constants of the loop point to tensor coordinate generator.
// ----------------------------------------------------------------------------
package lptc_pkg;

    localparam int COORD_W    = 32;   // flattened coordinate
    localparam int BOUND_W    = 16;   // factorized bound / coordinate
    localparam int COEF_W     = 16;   // signed coefficient
    localparam int SLOTS      = 4;    // slots per flattened dim
    localparam int STEP_BITS  = 4;    // quotient bits per divider stage
    localparam int STEPS      = COORD_W / STEP_BITS;
    localparam int MAX_FLAT   = 4;
    localparam int MAX_FACT   = 8;
    localparam int MAX_SPACES = 3;
    localparam int MAX_SDIMS  = 4;
    localparam int MAX_TERMS  = 2;
    localparam int MAX_COEFFS = 4;
    localparam int OUT_W      = 34;
    localparam int PROD_W     = COEF_W + BOUND_W + 1;
    localparam int IDX_W      = 2;
    localparam int DIM_W      = 3;
    localparam int SEL_W      = 3;
    localparam int CFG_W      = 64;
    localparam int PROJ_W     = 56;
    localparam int ADDR_W     = 6;

    localparam logic [SEL_W-1:0] SEL_UNITY = 3'd4;

    // register indexes (paddr[5:3])
    localparam logic [2:0] REG_BOUNDS_LO = 3'd0;
    localparam logic [2:0] REG_BOUNDS_HI = 3'd1;
    localparam logic [2:0] REG_SLOT_MAP  = 3'd2;
    localparam logic [2:0] REG_COEFFS    = 3'd3;
    localparam logic [2:0] REG_PROJ_0    = 3'd4;
    localparam logic [2:0] REG_PROJ_1    = 3'd5;
    localparam logic [2:0] REG_PROJ_2    = 3'd6;

    localparam logic [CFG_W-1:0] BOUNDS_RESET = 64'h0001_0001_0001_0001;

    // one divider lane: running dividend/quotient, partial remainder, slot results
    typedef struct packed {
        logic [COORD_W-1:0]              n;
        logic [BOUND_W-1:0]              r;
        logic [SLOTS-1:0][BOUND_W-1:0]   rems;
    } t_lane;

    // decoded slot: used, effective bound (zero already mapped to one)
    typedef struct packed {
        logic               vld;
        logic [BOUND_W-1:0] bnd;
    } t_slot;

    // projection term, bit 6 valid, 5:3 coefficient select, 2:0 dim
    typedef struct packed {
        logic             vld;
        logic [SEL_W-1:0] sel;
        logic [DIM_W-1:0] dim;
    } t_term;

    typedef t_term [MAX_SDIMS-1:0][MAX_TERMS-1:0] t_proj;
    typedef logic [MAX_FACT-1:0][BOUND_W-1:0]     t_fact;
    typedef logic [MAX_COEFFS-1:0][COEF_W-1:0]    t_coefs;

endpackage

### hdl/lptc_div_stage.sv
// ----------------------------------------------------------------------------
// lptc_div_stage
// One registered stage of the mixed-radix divider: STEP_BITS restoring
// division steps of one slot, for every flattened lane in parallel.
// ----------------------------------------------------------------------------
module lptc_div_stage
    import lptc_pkg::*;
#(
    parameter int LANES = 4,
    parameter int SLOT  = 0,
    parameter int STEP  = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  t_lane [LANES-1:0]                   i_lane,
    input  t_slot [LANES-1:0][SLOTS-1:0]        i_slots,
    output logic                                o_valid,
    output t_lane [LANES-1:0]                   o_lane
);

    logic              r_valid;
    t_lane [LANES-1:0] r_lane;
    t_lane [LANES-1:0] n_lane;

    always_comb begin
        logic [COORD_W-1:0] num;
        logic [BOUND_W-1:0] rem;
        logic [BOUND_W:0]   trial;
        n_lane = i_lane;
        for (int f = 0; f < LANES; f++) begin
            num   = i_lane[f].n;
            rem   = (STEP == 0) ? '0 : i_lane[f].r;
            trial = '0;
            if (i_slots[f][SLOT].vld) begin
                for (int b = 0; b < STEP_BITS; b++) begin
                    trial = {rem, num[COORD_W-1]};
                    num   = {num[COORD_W-2:0], 1'b0};
                    if (trial >= {1'b0, i_slots[f][SLOT].bnd}) begin
                        trial  = trial - {1'b0, i_slots[f][SLOT].bnd};
                        num[0] = 1'b1;
                    end
                    rem = trial[BOUND_W-1:0];
                end
                n_lane[f].n = num;
                n_lane[f].r = rem;
                if (STEP == STEPS - 1) begin
                    n_lane[f].rems[SLOT] = rem;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

### hdl/lptc_proj.sv
// ----------------------------------------------------------------------------
// lptc_proj
// Holds one item's factorized coordinates and walks the data spaces:
// product stage, then sum into the output register (one space per cycle while the output is not stalled).
// ----------------------------------------------------------------------------
module lptc_proj
    import lptc_pkg::*;
#(
    parameter int FACT_DIMS     = 8,
    parameter int DATA_SPACES   = 3,
    parameter int SPACE_DIMS    = 4,
    parameter int TERMS_PER_DIM = 2,
    parameter int NUM_COEFFS    = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  t_fact                                 i_fact,
    input  logic                                  i_zero,
    input  t_proj [MAX_SPACES-1:0]                i_proj,
    input  t_coefs                                i_coefs,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [IDX_W-1:0]                      o_index,
    output logic [MAX_SDIMS-1:0][OUT_W-1:0]       o_coords,
    output logic                                  o_zero,
    output logic                                  o_last
);

    localparam logic [IDX_W-1:0] LAST_SP = IDX_W'(DATA_SPACES - 1);

    // hold register
    logic              r_hv;
    t_fact             r_fact;
    logic [IDX_W-1:0]  r_sp;
    // product stage
    logic                                            r_mv;
    logic [IDX_W-1:0]                                r_msp;
    logic [MAX_SDIMS-1:0][MAX_TERMS-1:0][PROD_W-1:0] r_mprod;
    logic [MAX_SDIMS-1:0][MAX_TERMS-1:0][PROD_W-1:0] n_mprod;
    // output register
    logic                                r_ov;
    logic [IDX_W-1:0]                    r_oidx;
    logic [MAX_SDIMS-1:0][OUT_W-1:0]     r_ocoord;
    logic [MAX_SDIMS-1:0][OUT_W-1:0]     n_ocoord;
    logic                                r_ozero;
    logic                                r_olast;

    logic adv_o, adv_m, take_m;

    assign adv_o   = !r_ov || i_ready;
    assign adv_m   = !r_mv || adv_o;
    assign take_m  = r_hv && adv_m;
    assign o_ready = !r_hv || (take_m && (r_sp == LAST_SP));

    always_comb begin
        t_proj                   proj;
        t_term                   term;
        logic [BOUND_W-1:0]      x;
        logic [COEF_W-1:0]       c;
        n_mprod = '0;
        proj    = i_proj[r_sp];
        for (int k = 0; k < SPACE_DIMS; k++) begin
            for (int t = 0; t < TERMS_PER_DIM; t++) begin
                term = proj[k][t];
                x    = (int'(term.dim) < FACT_DIMS) ? r_fact[term.dim] : '0;
                c    = i_coefs[term.sel[1:0]];
                if (term.vld) begin
                    if (term.sel == SEL_UNITY) begin
                        n_mprod[k][t] = PROD_W'(x);
                    end else if (int'(term.sel) < NUM_COEFFS) begin
                        n_mprod[k][t] = $signed({{(PROD_W-BOUND_W){1'b0}}, x})
                                      * $signed({{(PROD_W-COEF_W){c[COEF_W-1]}}, c});
                    end
                end
            end
        end
    end

    always_comb begin
        n_ocoord = '0;
        for (int k = 0; k < MAX_SDIMS; k++) begin
            for (int t = 0; t < MAX_TERMS; t++) begin
                n_ocoord[k] = n_ocoord[k]
                            + {r_mprod[k][t][PROD_W-1], r_mprod[k][t]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_sp <= '0;
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_ready) begin
                r_hv <= i_valid;
                r_sp <= '0;
            end else if (take_m) begin
                r_sp <= r_sp + IDX_W'(1);
            end
            if (adv_m) begin
                r_mv <= r_hv;
            end
            if (adv_o) begin
                r_ov <= r_mv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_fact <= i_fact;
        end
        if (adv_m) begin
            r_msp   <= r_sp;
            r_mprod <= n_mprod;
        end
        if (adv_o) begin
            r_oidx   <= r_msp;
            r_ocoord <= n_ocoord;
            r_ozero  <= i_zero;
            r_olast  <= (r_msp == LAST_SP);
        end
    end

    assign o_valid  = r_ov;
    assign o_index  = r_oidx;
    assign o_coords = r_ocoord;
    assign o_zero   = r_ozero;
    assign o_last   = r_olast;

    a_last_is_final_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_olast |-> r_oidx == LAST_SP)
        else $error("last flag on a non-final space");

    a_space_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hv |-> r_sp <= LAST_SP)
        else $error("space counter ran past the final space");

    a_new_item_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && i_valid |=> r_hv && r_sp == '0)
        else $error("new item not loaded at space zero");

endmodule

### hdl/loop_point_to_tensor_coords.sv
// ----------------------------------------------------------------------------
// loop_point_to_tensor_coords
// Mixed-radix affine address generator: splits four flattened loop
// coordinates into factorized coordinates and projects them into the
// coordinates of each data space.
// ----------------------------------------------------------------------------
//
//  channel   dir  transaction                 fields
//  s_axis    in   one operation point         tdata: flat_coord_0..3
//  m_axis    out  one data space's coords     tdata: space_coord_0..3,
//                                             tuser: space_index, zero_bound_seen
//  apb       in   register write / read       7 registers, 64 bit, at 8*i
//
//  Rate: an item produces DATA_SPACES output transactions (3 by default), one
//  per cycle while m_axis_tready is high, set by the single output channel.
//  An item passes the divider, then the hold, product and output registers.
//  The divider is 32 stages deep: per slot 8 stages of 4 restoring steps.
//  Reset clears all valid bits and loads the register reset values.
//  Stalls: the whole divider pipeline holds on a single enable while its
//  last stage waits for the projection unit; nothing is dropped or repeated.
//  Registers may only be written while no transaction is in flight.
//
module loop_point_to_tensor_coords
    import lptc_pkg::*;
#(
    parameter int FLAT_DIMS     = 4,
    parameter int FACT_DIMS     = 8,
    parameter int DATA_SPACES   = 3,
    parameter int SPACE_DIMS    = 4,
    parameter int TERMS_PER_DIM = 2,
    parameter int NUM_COEFFS    = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [CFG_W-1:0]       pwdata,
    output logic [CFG_W-1:0]       prdata,
    output logic                   pready,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [127:0]           s_axis_tdata,   // flat_coord_0, _1, _2, _3
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [135:0]           m_axis_tdata,   // space_coord_0, _1, _2, _3
    output logic [2:0]             m_axis_tuser,   // space_index, zero_bound_seen
    output logic                   m_axis_tlast
);

    localparam int NSTG = SLOTS * STEPS;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0]  r_bnd_lo, r_bnd_hi, r_slot_map;
    t_coefs            r_coefs;
    t_proj [MAX_SPACES-1:0] r_proj;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bnd_lo   <= BOUNDS_RESET;
            r_bnd_hi   <= BOUNDS_RESET;
            r_slot_map <= '0;
            r_coefs    <= '0;
            r_proj     <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                REG_BOUNDS_LO: r_bnd_lo   <= pwdata;
                REG_BOUNDS_HI: r_bnd_hi   <= pwdata;
                REG_SLOT_MAP:  r_slot_map <= pwdata;
                REG_COEFFS:    r_coefs    <= pwdata;
                REG_PROJ_0:    r_proj[0]  <= pwdata[PROJ_W-1:0];
                REG_PROJ_1:    r_proj[1]  <= pwdata[PROJ_W-1:0];
                REG_PROJ_2:    r_proj[2]  <= pwdata[PROJ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_BOUNDS_LO: prdata = r_bnd_lo;
            REG_BOUNDS_HI: prdata = r_bnd_hi;
            REG_SLOT_MAP:  prdata = r_slot_map;
            REG_COEFFS:    prdata = r_coefs;
            REG_PROJ_0:    prdata = CFG_W'(r_proj[0]);
            REG_PROJ_1:    prdata = CFG_W'(r_proj[1]);
            REG_PROJ_2:    prdata = CFG_W'(r_proj[2]);
            default:       prdata = '0;
        endcase
    end

    // ---------------- slot decode ----------------
    // A slot is used when its valid bit is set and its dim exists. A zero
    // bound divides as one and, on a used slot, raises the flag; the flag depends on config
    // only, so it is the same on every result.
    t_slot [FLAT_DIMS-1:0][SLOTS-1:0] slots;
    logic [FLAT_DIMS-1:0][SLOTS-1:0][DIM_W-1:0] slot_dim;
    logic [2*CFG_W-1:0] all_bounds;
    logic               zero_seen;

    assign all_bounds = {r_bnd_hi, r_bnd_lo};

    always_comb begin
        logic [3:0]         code;
        logic [BOUND_W-1:0] b;
        zero_seen = 1'b0;
        for (int f = 0; f < FLAT_DIMS; f++) begin
            for (int s = 0; s < SLOTS; s++) begin
                code           = r_slot_map[4*(SLOTS*f+s) +: 4];
                slot_dim[f][s] = code[DIM_W-1:0];
                b              = all_bounds[BOUND_W*code[DIM_W-1:0] +: BOUND_W];
                slots[f][s].vld = code[3] && (int'(code[DIM_W-1:0]) < FACT_DIMS);
                slots[f][s].bnd = (b == '0) ? BOUND_W'(1) : b;
                if (slots[f][s].vld && b == '0) begin
                    zero_seen = 1'b1;
                end
            end
        end
    end

    // ---------------- divider pipeline ----------------
    t_lane [FLAT_DIMS-1:0] w_lane  [0:NSTG];
    logic                  w_valid [0:NSTG];
    logic                  proj_ready;
    logic                  adv;

    // whole pipeline moves together; the last stage waits on the projector
    assign adv           = !w_valid[NSTG] || proj_ready;
    assign s_axis_tready = adv;
    assign w_valid[0]    = s_axis_tvalid;

    for (genvar f = 0; f < FLAT_DIMS; f++) begin : g_lane_in
        assign w_lane[0][f].n    = s_axis_tdata[COORD_W*f +: COORD_W];
        assign w_lane[0][f].r    = '0;
        assign w_lane[0][f].rems = '0;
    end

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        lptc_div_stage #(
            .LANES (FLAT_DIMS),
            .SLOT  (g / STEPS),
            .STEP  (g % STEPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (w_valid[g]),
            .i_lane  (w_lane[g]),
            .i_slots (slots),
            .o_valid (w_valid[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    // ---------------- factorized coordinates ----------------
    // later slots (flat dim major, then slot order) overwrite earlier ones
    t_fact w_fact;

    always_comb begin
        w_fact = '0;
        for (int f = 0; f < FLAT_DIMS; f++) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (slots[f][s].vld) begin
                    w_fact[slot_dim[f][s]] = w_lane[NSTG][f].rems[s];
                end
            end
        end
    end

    // ---------------- projection ----------------
    logic [IDX_W-1:0]                  out_idx;
    logic [MAX_SDIMS-1:0][OUT_W-1:0]   out_coords;
    logic                              out_zero;

    lptc_proj #(
        .FACT_DIMS     (FACT_DIMS),
        .DATA_SPACES   (DATA_SPACES),
        .SPACE_DIMS    (SPACE_DIMS),
        .TERMS_PER_DIM (TERMS_PER_DIM),
        .NUM_COEFFS    (NUM_COEFFS)
    ) u_proj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[NSTG]),
        .o_ready  (proj_ready),
        .i_fact   (w_fact),
        .i_zero   (zero_seen),
        .i_proj   (r_proj),
        .i_coefs  (r_coefs),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_index  (out_idx),
        .o_coords (out_coords),
        .o_zero   (out_zero),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = out_coords;
    assign m_axis_tuser = {out_zero, out_idx};

    a_div_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[NSTG] && !adv |=> w_valid[NSTG] && $stable(w_lane[NSTG]))
        else $error("divider output changed while stalled");

endmodule
